@@ design/rmeu_pkg.sv @@
`default_nettype none
package rmeu_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned NumRegs = 30;
  localparam logic [DataW-1:0] SpResetDefault = 32'd12580864;
  localparam logic [DataW-1:0] HiMask = 32'hFFFF0000;
  localparam logic [DataW-1:0] LoMask = 32'h0000FFFF;
  localparam logic [4:0] RegSp = 5'd3;
  localparam logic [4:0] RegPc = 5'd1;

  typedef enum logic [5:0] {
    OP_ADD = 6'd0, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_NAND, OP_NOR, OP_XNOR,
    OP_NEG, OP_NOT, OP_DIV, OP_IDIV, OP_REM, OP_IREM, OP_MUL, OP_IMUL,
    OP_CMP, OP_MV, OP_MVE, OP_MVO, OP_TSBI, OP_TSI, OP_TSB, OP_TS,
    OP_LSL, OP_LSR, OP_ANDI, OP_ORI, OP_HLT, OP_ADDI, OP_LDLX, OP_LDHX,
    OP_LDL, OP_LDH
  } op_t;

  typedef struct packed {
    logic [5:0] op;
    logic       illegal;
    logic [7:0] fa;
    logic [7:0] fb;
    logic [7:0] fc;
  } instr_t;

  typedef struct packed {
    logic [DataW-1:0] next_pc;
    logic             wrote;
    logic [DataW-1:0] value;
    logic             halted;
    logic             fault;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_MUL, ST_DIV, ST_EXEC, ST_OUT
  } exec_state_t;
endpackage
`default_nettype wire

@@ design/rmeu_front.sv @@
`default_nettype none
module rmeu_front import rmeu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic [5:0] op,
  input  wire logic [7:0] fa,
  input  wire logic [7:0] fb,
  input  wire logic [7:0] fc,
  output logic      q_valid,
  input  wire logic q_pop,
  output instr_t    q_head
);
  instr_t q_r [2];
  logic [1:0] cnt_r;
  logic rd_r, wr_r;
  logic push;
  logic use_a, use_b, use_c, bad;
  instr_t item;

  always_comb begin
    use_a = 1'b1; use_b = 1'b1; use_c = 1'b1;
    if (op == OP_NEG || op == OP_NOT || op == OP_MV || op == OP_TSBI || op == OP_TSI ||
        op == OP_ANDI || op == OP_ORI || op == OP_ADDI) begin
      use_b = 1'b0;
    end else if (op == OP_LDLX || op == OP_LDHX || op == OP_LDL || op == OP_LDH) begin
      use_a = 1'b0; use_b = 1'b0;
    end else if (op == OP_HLT) begin
      use_a = 1'b0; use_b = 1'b0; use_c = 1'b0;
    end
    bad = (op > OP_LDH) || (use_a && fa > 8'd31) || (use_b && fb > 8'd31) ||
          (use_c && fc > 8'd31);
    item = '{op: op, illegal: bad, fa: fa, fb: fb, fc: fc};
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_head = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= item;
    if (!rst_n) begin
      cnt_r <= '0; rd_r <= 1'b0; wr_r <= 1'b0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (q_pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule
`default_nettype wire

@@ design/rmeu_div.sv @@
`default_nettype none
module rmeu_div import rmeu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic [DataW-1:0] num,
  input  wire logic [DataW-1:0] den,
  output logic busy,
  output logic [DataW-1:0] quot,
  output logic [DataW-1:0] rem
);
  logic [DataW-1:0] q_r, r_r, d_r;
  logic [5:0] n_r;
  logic [DataW:0] tr;
  logic [DataW:0] diff;

  assign tr = {r_r, q_r[DataW-1]};
  assign diff = tr - {1'b0, d_r};
  assign busy = (n_r != 6'd0);
  assign quot = q_r;
  assign rem = r_r;

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= num; r_r <= '0; d_r <= den;
    end else if (busy) begin
      if (!diff[DataW]) begin
        r_r <= diff[DataW-1:0]; q_r <= {q_r[DataW-2:0], 1'b1};
      end else begin
        r_r <= tr[DataW-1:0]; q_r <= {q_r[DataW-2:0], 1'b0};
      end
    end
    if (!rst_n) n_r <= '0;
    else if (start) n_r <= 6'(DataW);
    else if (busy) n_r <= n_r - 6'd1;
  end
endmodule
`default_nettype wire

@@ design/rmeu_back.sv @@
`default_nettype none
module rmeu_back import rmeu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  output logic      q_pop,
  input  wire instr_t q_head,
  input  wire logic cfg_valid,
  input  wire logic [DataW-1:0] cfg_data,
  output logic      res_valid,
  input  wire logic res_ready,
  output result_t   res
);
  exec_state_t st_r, st_nxt;
  logic [DataW-1:0] rf_r [NumRegs];
  logic [DataW-1:0] pc_r, a_r, b_r, c_r;
  logic [63:0] prod_r;
  instr_t ins_r;
  result_t res_r, res_nxt;
  logic dstart, dbusy, dz, neg_q, neg_r;
  logic [DataW-1:0] dq, drem, na, nb, v;
  logic wr;

  function automatic logic [DataW-1:0] rd(input logic [4:0] r, input logic [DataW-1:0] pc,
                                         input logic [DataW-1:0] x);
    if (r == 5'd0) return '0;
    if (r == RegPc) return pc;
    return x;
  endfunction

  logic [4:0] ia, ib, ic;
  assign ia = q_head.fa[4:0] - 5'd2;
  assign ib = q_head.fb[4:0] - 5'd2;
  assign ic = q_head.fc[4:0] - 5'd2;

  rmeu_div u_div (.clk, .rst_n, .start(dstart), .num(na), .den(nb),
                  .busy(dbusy), .quot(dq), .rem(drem));

  assign dz = (b_r == '0);
  assign na = (ins_r.op == OP_IDIV || ins_r.op == OP_IREM) && a_r[DataW-1] ? -a_r : a_r;
  assign nb = (ins_r.op == OP_IDIV || ins_r.op == OP_IREM) && b_r[DataW-1] ? -b_r : b_r;
  assign neg_q = (ins_r.op == OP_IDIV) && (a_r[DataW-1] ^ b_r[DataW-1]);
  assign neg_r = (ins_r.op == OP_IREM) && a_r[DataW-1];
  assign dstart = (st_r == ST_MUL) && (st_nxt == ST_DIV);
  assign res_valid = (st_r == ST_OUT);
  assign res = res_r;

  always_comb begin
    logic [DataW-1:0] imm, fbx, fl;
    imm = {16'd0, ins_r.fb, ins_r.fa};
    fbx = {24'd0, ins_r.fb};
    v = '0; wr = 1'b1;
    fl = '0;
    unique case (ins_r.op)
      OP_ADD: v = a_r + b_r;
      OP_SUB: v = a_r - b_r;
      OP_AND: v = a_r & b_r;
      OP_OR: v = a_r | b_r;
      OP_XOR: v = a_r ^ b_r;
      OP_NAND: v = ~(a_r & b_r);
      OP_NOR: v = ~(a_r | b_r);
      OP_XNOR: v = ~(a_r ^ b_r);
      OP_NEG: v = -a_r;
      OP_NOT: v = ~a_r;
      OP_DIV, OP_IDIV: v = neg_q ? -dq : dq;
      OP_REM, OP_IREM: v = neg_r ? -drem : drem;
      OP_MUL, OP_IMUL: v = prod_r[DataW-1:0];
      OP_CMP: begin
        fl[10] = (prod_r[63:32] != '0);
        fl[9] = (a_r + b_r) < a_r;
        fl[8] = (a_r - b_r) < a_r;
        fl[7] = a_r > b_r;
        fl[6] = a_r < b_r;
        fl[5] = $signed(a_r) > $signed(b_r);
        fl[4] = $signed(a_r) < $signed(b_r);
        fl[3] = a_r != b_r;
        fl[2] = a_r == b_r;
        fl[1] = b_r == '0;
        fl[0] = a_r == '0;
        v = fl;
      end
      OP_MV: v = a_r;
      OP_MVE: begin v = b_r; wr = (a_r != '0); end
      OP_MVO: begin v = b_r; wr = (a_r == '0); end
      OP_TSBI: v = DataW'(ins_r.fb < 8'd32 && a_r[ins_r.fb[4:0]]);
      OP_TSI: v = DataW'((a_r & fbx) != '0);
      OP_TSB: v = DataW'(b_r < 32 && a_r[b_r[4:0]]);
      OP_TS: v = DataW'((a_r & b_r) != '0);
      OP_LSL: v = (b_r < 32) ? a_r << b_r[4:0] : '0;
      OP_LSR: v = (b_r < 32) ? a_r >> b_r[4:0] : '0;
      OP_ANDI: v = a_r & fbx;
      OP_ORI: v = a_r | fbx;
      OP_HLT: wr = 1'b0;
      OP_ADDI: v = a_r + fbx;
      OP_LDLX: v = imm;
      OP_LDHX: v = imm << 16;
      OP_LDL: v = (c_r & HiMask) | imm;
      OP_LDH: v = (c_r & LoMask) | (imm << 16);
      default: wr = 1'b0;
    endcase
  end

  always_comb begin
    logic flt, hlt, w;
    st_nxt = st_r;
    q_pop = 1'b0;
    flt = ins_r.illegal || ((ins_r.op == OP_DIV || ins_r.op == OP_IDIV ||
          ins_r.op == OP_REM || ins_r.op == OP_IREM) && dz);
    hlt = !flt && ins_r.op == OP_HLT;
    w = !flt && wr && ins_r.fc != 8'd0;
    res_nxt.fault = flt;
    res_nxt.halted = hlt;
    res_nxt.wrote = w;
    res_nxt.value = w ? v : '0;
    res_nxt.next_pc = (flt || hlt) ? pc_r : (w && ins_r.fc == 8'd1) ? v : pc_r + 32'd4;
    unique case (st_r)
      ST_IDLE: if (q_valid) begin q_pop = 1'b1; st_nxt = ST_READ; end
      ST_READ: st_nxt = ST_MUL;
      ST_MUL: st_nxt = (ins_r.op == OP_DIV || ins_r.op == OP_IDIV || ins_r.op == OP_REM ||
                        ins_r.op == OP_IREM) && !ins_r.illegal && !dz ? ST_DIV : ST_EXEC;
      ST_DIV: if (!dbusy) st_nxt = ST_EXEC;
      ST_EXEC: st_nxt = ST_OUT;
      ST_OUT: if (res_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && q_valid) begin
      ins_r <= q_head;
      a_r <= rd(q_head.fa[4:0], pc_r, (ia < 5'(NumRegs)) ? rf_r[ia] : '0);
      b_r <= rd(q_head.fb[4:0], pc_r, (ib < 5'(NumRegs)) ? rf_r[ib] : '0);
      c_r <= rd(q_head.fc[4:0], pc_r, (ic < 5'(NumRegs)) ? rf_r[ic] : '0);
    end
    if (st_r == ST_READ) prod_r <= {32'd0, a_r} * {32'd0, b_r};
    if (st_r == ST_EXEC) res_r <= res_nxt;
    if (!rst_n) begin
      st_r <= ST_IDLE;
      pc_r <= '0;
      for (int i = 0; i < NumRegs; i++)
        rf_r[i] <= (i == int'(RegSp) - 2) ? SpResetDefault : '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_EXEC) begin
        pc_r <= res_nxt.next_pc;
        if (res_nxt.wrote && ins_r.fc > 8'd1)
          rf_r[ins_r.fc[4:0] - 5'd2] <= res_nxt.value;
      end
      if (cfg_valid) rf_r[RegSp - 5'd2] <= cfg_data;
    end
  end
endmodule
`default_nettype wire

@@ design/register_machine_execute_unit_core.sv @@
`default_nettype none
// Execute unit of a small register machine.
// The in_ channel carries one instruction per item; tdata holds, from the
// lowest bit, op[5:0], field_a[13:6], field_b[21:14], field_c[29:22].
// The out_ channel returns one result per instruction with tdata holding
// next_pc[31:0], wrote_register[32], write_value[64:33], halted[65], fault[66].
// The cfg_ channel loads register three, the stack pointer, at once;
// write it only while the unit is idle.
// A front end checks opcodes and register indexes and fills a two-entry
// queue. The back end reads operands, registers the product, executes and
// registers the result, and takes the next instruction only after the
// result is handed off; divide and remainder also wait for a
// one-bit-per-cycle divider. The front keeps accepting while the queue has
// room, so a stalled receiver only blocks input once the queue is full.
// After reset the pc is zero, all registers are zero and register three
// holds the stack pointer reset value.
module register_machine_execute_unit_core import rmeu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,  // op, field_a, field_b, field_c
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata, // next_pc, wrote_register, write_value, halted, fault
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);
  logic q_valid, q_pop;
  instr_t q_head;
  result_t res;

  assign cfg_ready = 1'b1;

  rmeu_front u_front (.clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .op(in_tdata[5:0]), .fa(in_tdata[13:6]), .fb(in_tdata[21:14]), .fc(in_tdata[29:22]),
    .q_valid, .q_pop, .q_head);

  rmeu_back u_back (.clk, .rst_n, .q_valid, .q_pop, .q_head, .cfg_valid, .cfg_data,
    .res_valid(out_tvalid), .res_ready(out_tready), .res);

  assign out_tdata = {5'd0, res.fault, res.halted, res.value, res.wrote, res.next_pc};
endmodule
`default_nettype wire

@@ design/rmeu_checker.sv @@
`default_nettype none
module rmeu_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic [71:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("hold");
  a_fault_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[66] |-> !out_tdata[32] && out_tdata[64:33] == '0)
    else $error("fault wrote");
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[65] && out_tdata[66])) else $error("halt and fault");
  a_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[32] |-> out_tdata[64:33] == '0) else $error("value");
endmodule

bind register_machine_execute_unit_core rmeu_checker u_chk (.clk, .rst_n, .out_tvalid,
  .out_tready, .out_tdata);
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import rmeu_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  register_machine_execute_unit_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        wrote;
    logic [31:0] value;
    logic        halted;
    logic        fault;
  } exec_result_t;

  typedef struct {
    op_t         op;
    logic [7:0]  fa;
    logic [7:0]  fb;
    logic [7:0]  fc;
    bit          typed;
    exec_result_t res;
  } stim_row_t;

  logic [31:0]  pc_q;
  logic [31:0]  regs_q [NumRegs];
  exec_result_t pending_results [$];
  int           errors = 0;
  int           n_items = 0;
  int           n_results = 0;
  int           n_faults = 0;
  int           in_idle_pct = 0;
  int           out_idle_pct = 0;
  longint       cycles = 0;

  function automatic logic [31:0] reg_read(logic [4:0] r);
    if (r == 5'd0) return 32'd0;
    if (r == RegPc) return pc_q;
    if (r - 5'd2 < NumRegs) return regs_q[r - 5'd2];
    return 32'd0;
  endfunction

  function automatic exec_result_t execute_instr(logic [5:0] op, logic [7:0] fa,
                                                 logic [7:0] fb, logic [7:0] fc);
    exec_result_t r;
    logic [31:0] a, b, v, imm, pc, sa, sb, nxt;
    logic [63:0] prod;
    longint ia, ib;
    bit use_a, use_b, use_c, wr, flt, hlt, pcw, wrote;
    pc = pc_q;
    imm = {16'd0, fb, fa};
    use_a = 1; use_b = 1; use_c = 1;
    wr = 1; flt = 0; hlt = 0; pcw = 0; wrote = 0; v = 0;
    if (op == OP_NEG || op == OP_NOT || op == OP_MV || op == OP_TSBI || op == OP_TSI ||
        op == OP_ANDI || op == OP_ORI || op == OP_ADDI) use_b = 0;
    else if (op >= OP_LDLX && op <= OP_LDH) begin
      use_a = 0; use_b = 0;
    end else if (op == OP_HLT) begin
      use_a = 0; use_b = 0; use_c = 0;
    end
    if (op > OP_LDH) flt = 1;
    if ((use_a && fa > 31) || (use_b && fb > 31) || (use_c && fc > 31)) flt = 1;
    a = reg_read(fa[4:0]);
    b = reg_read(fb[4:0]);
    if (!flt) begin
      case (op)
        OP_ADD:  v = a + b;
        OP_SUB:  v = a - b;
        OP_AND:  v = a & b;
        OP_OR:   v = a | b;
        OP_XOR:  v = a ^ b;
        OP_NAND: v = ~(a & b);
        OP_NOR:  v = ~(a | b);
        OP_XNOR: v = ~(a ^ b);
        OP_NEG:  v = 32'd0 - a;
        OP_NOT:  v = ~a;
        OP_DIV, OP_IDIV, OP_REM, OP_IREM: begin
          if (b == 0) flt = 1;
          else if (op == OP_DIV) v = a / b;
          else if (op == OP_REM) v = a % b;
          else begin
            ia = longint'(signed'(a));
            ib = longint'(signed'(b));
            v = (op == OP_IDIV) ? 32'(ia / ib) : 32'(ia % ib);
          end
        end
        OP_MUL, OP_IMUL: v = a * b;
        OP_CMP: begin
          prod = 64'(a) * 64'(b);
          sa = a ^ 32'h80000000;
          sb = b ^ 32'h80000000;
          v = {21'd0, prod[63:32] != 0, (a + b) < a, (a - b) < a, a > b, a < b,
               sa > sb, sa < sb, a != b, a == b, b == 0, a == 0};
        end
        OP_MV:   v = a;
        OP_MVE:  if (a != 0) v = b; else wr = 0;
        OP_MVO:  if (a == 0) v = b; else wr = 0;
        OP_TSBI: v = (fb < 32) ? 32'(a[fb[4:0]]) : 32'd0;
        OP_TSI:  v = 32'((a & 32'(fb)) != 0);
        OP_TSB:  v = (b < 32) ? 32'(a[b[4:0]]) : 32'd0;
        OP_TS:   v = 32'((a & b) != 0);
        OP_LSL:  v = (b < 32) ? a << b : 32'd0;
        OP_LSR:  v = (b < 32) ? a >> b : 32'd0;
        OP_ANDI: v = a & 32'(fb);
        OP_ORI:  v = a | 32'(fb);
        OP_HLT: begin
          hlt = 1; wr = 0;
        end
        OP_ADDI: v = a + 32'(fb);
        OP_LDLX: v = imm;
        OP_LDHX: v = imm << 16;
        OP_LDL:  v = (reg_read(fc[4:0]) & HiMask) | imm;
        default: v = (reg_read(fc[4:0]) & LoMask) | (imm << 16);
      endcase
    end
    if (flt || !wr || fc == 0) v = 0;
    else begin
      wrote = 1;
      if (fc == 1) begin
        pc_q = v; pcw = 1;
      end else if (fc - 2 < NumRegs) regs_q[fc - 2] = v;
    end
    if (flt || hlt) nxt = pc;
    else if (pcw) nxt = pc_q;
    else nxt = pc + 32'd4;
    pc_q = nxt;
    r.next_pc = nxt; r.wrote = wrote; r.value = v;
    r.halted = hlt && !flt; r.fault = flt;
    return r;
  endfunction

  task automatic send_item(logic [5:0] op, logic [7:0] fa, logic [7:0] fb, logic [7:0] fc);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, fc, fb, fa, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic issue(logic [5:0] op, logic [7:0] fa, logic [7:0] fb, logic [7:0] fc);
    exec_result_t r;
    r = execute_instr(op, fa, fb, fc);
    if (r.fault) n_faults++;
    pending_results.push_back(r);
    n_items++;
    send_item(op, fa, fb, fc);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_sp_reset(logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    regs_q[RegSp - 2] = val;
  endtask

  always @(posedge clk) begin
    exec_result_t got, exp_r;
    cycles <= cycles + 1;
    out_tready <= rst_n && ($urandom_range(99) >= out_idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      got.next_pc = out_tdata[31:0];
      got.wrote = out_tdata[32];
      got.value = out_tdata[64:33];
      got.halted = out_tdata[65];
      got.fault = out_tdata[66];
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result item with no expectation waiting: %h", got);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.next_pc !== exp_r.next_pc) begin
          $error("next_pc expected %h actual %h", exp_r.next_pc, got.next_pc); errors++;
        end
        if (got.wrote !== exp_r.wrote) begin
          $error("wrote_register expected %b actual %b", exp_r.wrote, got.wrote); errors++;
        end
        if (got.value !== exp_r.value) begin
          $error("write_value expected %h actual %h", exp_r.value, got.value); errors++;
        end
        if (got.halted !== exp_r.halted) begin
          $error("halted expected %b actual %b", exp_r.halted, got.halted); errors++;
        end
        if (got.fault !== exp_r.fault) begin
          $error("fault expected %b actual %b", exp_r.fault, got.fault); errors++;
        end
      end
    end
    if (cycles > 2000000) begin
      $display("Timeout waiting for result items.");
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] rand_reg();
    return ($urandom_range(99) < 3) ? 8'($urandom_range(255, 32)) : 8'($urandom_range(31));
  endfunction

  task automatic random_phase(int count);
    logic [5:0] op;
    logic [7:0] fa, fb, fc;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(99) < 4) ? 6'($urandom_range(63, 34)) : 6'($urandom_range(33));
      if ((op == OP_DIV || op == OP_IDIV || op == OP_REM || op == OP_IREM) &&
          $urandom_range(3) != 0) op = 6'($urandom_range(9));
      fa = rand_reg();
      fb = rand_reg();
      fc = rand_reg();
      if (op inside {OP_TSBI, OP_TSI, OP_ANDI, OP_ORI, OP_ADDI, OP_LDLX, OP_LDHX, OP_LDL,
                     OP_LDH}) begin
        fb = 8'($urandom);
        if (op >= OP_LDLX) fa = 8'($urandom);
      end
      if (fc == 1 && $urandom_range(3) != 0) fc = 8'($urandom_range(31, 2));
      if (op == OP_HLT && $urandom_range(1) == 0) op = OP_LDHX;
      issue(op, fa, fb, fc);
    end
  endtask

  stim_row_t dir_rows [$];

  initial begin
    stim_row_t row;
    exec_result_t r;
    pc_q = 0;
    foreach (regs_q[i]) regs_q[i] = 0;
    regs_q[RegSp - 2] = SpResetDefault;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: after reset the stack pointer reads its default.
    dir_rows = '{
      '{OP_MV,   8'd3,   8'd0,   8'd4,  1, '{32'd4, 1'b1, SpResetDefault, 1'b0, 1'b0}},
      '{OP_LDLX, 8'hFF,  8'hFF,  8'd5,  1, '{32'd8, 1'b1, 32'h0000FFFF, 1'b0, 1'b0}},
      '{OP_LDHX, 8'hFF,  8'hFF,  8'd6,  1, '{32'd12, 1'b1, 32'hFFFF0000, 1'b0, 1'b0}},
      '{OP_DIV,  8'd5,   8'd0,   8'd7,  1, '{32'd12, 1'b0, 32'd0, 1'b0, 1'b1}},
      '{OP_ADD,  8'd255, 8'd2,   8'd7,  1, '{32'd12, 1'b0, 32'd0, 1'b0, 1'b1}},
      '{op_t'(6'd63), 8'd2, 8'd2, 8'd7, 1, '{32'd12, 1'b0, 32'd0, 1'b0, 1'b1}},
      '{OP_HLT,  8'd200, 8'd200, 8'd200, 1, '{32'd12, 1'b0, 32'd0, 1'b1, 1'b0}},
      '{OP_ADD,  8'd5,   8'd6,   8'd0,  1, '{32'd16, 1'b0, 32'd0, 1'b0, 1'b0}},
      '{OP_LDHX, 8'h00,  8'h80,  8'd8,  0, '0},
      '{OP_NEG,  8'd5,   8'd0,   8'd9,  0, '0},
      '{OP_IDIV, 8'd8,   8'd9,   8'd10, 0, '0},
      '{OP_IREM, 8'd8,   8'd9,   8'd10, 0, '0},
      '{OP_LSL,  8'd6,   8'd5,   8'd11, 0, '0},
      '{OP_LSR,  8'd6,   8'd3,   8'd11, 0, '0},
      '{OP_TSB,  8'd6,   8'd5,   8'd12, 0, '0},
      '{OP_TSBI, 8'd6,   8'd200, 8'd12, 0, '0},
      '{OP_CMP,  8'd6,   8'd6,   8'd13, 0, '0},
      '{OP_MVE,  8'd0,   8'd6,   8'd14, 0, '0},
      '{OP_MVO,  8'd0,   8'd6,   8'd14, 0, '0},
      '{OP_ADDI, 8'd1,   8'd255, 8'd31, 0, '0},
      '{OP_LDL,  8'h40,  8'h00,  8'd1,  0, '0},
      '{OP_LDH,  8'h00,  8'h00,  8'd1,  0, '0},
      '{OP_MUL,  8'd6,   8'd6,   8'd15, 0, '0},
      '{OP_REM,  8'd6,   8'd5,   8'd16, 0, '0}
    };
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      r = execute_instr(row.op, row.fa, row.fb, row.fc);
      if (row.typed && r !== row.res) begin
        $error("directed row %0d predicted %h, table says %h", i, r, row.res);
        errors++;
      end
      if (r.fault) n_faults++;
      pending_results.push_back(r);
      n_items++;
      send_item(row.op, row.fa, row.fb, row.fc);
    end
    drain();

    in_idle_pct = 35; out_idle_pct = 59;
    write_sp_reset(32'd0);
    random_phase(370);
    drain();
    in_idle_pct = 59; out_idle_pct = 35;
    write_sp_reset(32'hFFFFFFFF);
    random_phase(370);
    drain();
    in_idle_pct = 0; out_idle_pct = 0;
    write_sp_reset(32'($urandom));
    random_phase(360);
    drain();

    $display("Covered %0d instruction items and %0d result items, %0d of them faults,",
             n_items, n_results, n_faults);
    $display("over four stack pointer reset settings and three idling patterns.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
